@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/sst_pkg.sv @@
// Types, constants and codes of the sorted set table.
`default_nettype none

package sst_pkg;

  localparam int unsigned CAPACITY  = 32;
  localparam int unsigned ELEM_BITS = 32;

  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;

  localparam int unsigned IN_BITS   = CMD_W + VALUE_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = STATUS_W + 1 + CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic [CNT_W-1:0]            count_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Row-wide shift command, qualified by the accept handshake.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

  typedef struct packed {
    status_e status;
    logic    found;
    count_t  count;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/sst_cell.sv @@
// One storage cell of the sorted row: holds an entry, compares, shifts.
`default_nettype none

module sst_cell (
  input  logic               clk_i,
  input  sst_pkg::cell_ctrl_t ctrl_i,
  input  sst_pkg::elem_t     key_i,
  input  logic               valid_i,
  input  sst_pkg::elem_t     left_data_i,
  input  logic               left_gt_i,
  input  sst_pkg::elem_t     right_data_i,
  output sst_pkg::elem_t     data_o,
  output logic               eq_o,
  output logic               gt_o
);
  import sst_pkg::*;

  elem_t data_q;
  elem_t data_d;

  assign data_o = data_q;
  assign eq_o   = valid_i && (data_q == key_i);
  assign gt_o   = valid_i && (data_q > key_i);

  // On insert, cells above the slot take their left neighbor; the first cell
  // that is greater than the key (or empty) takes the key itself.
  // On delete, every cell at or above the hit takes its right neighbor.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.insert) begin
      if (left_gt_i) begin
        data_d = left_data_i;
      end else if (gt_o || !valid_i) begin
        data_d = key_i;
      end
    end else if (ctrl_i.remove) begin
      if (eq_o || gt_o) begin
        data_d = right_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

@@ rtl/sorted_set_table.sv @@
// Sorted set table: a row of CAPACITY cells holds distinct signed values in
// ascending order. Every cell compares its entry with the command's value in
// the same cycle, and on insert or delete the cells past the slot load their
// left or right neighbor, so one command is taken every clock cycle while the
// result register is free or drains, and its result beat appears in the output
// register in the next cycle. The input is still taken while a result waits,
// as long as that result leaves in the same cycle.
`default_nettype none

module sorted_set_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] cmd, [33:2] value, upper bits zero
  input  logic [sst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [2] found, [8:3] count, upper bits zero
  output logic [sst_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import sst_pkg::*;

  logic                     accept;
  logic [CMD_W-1:0]         cmd;
  logic signed [VALUE_W-1:0] value;
  elem_t                    key;

  elem_t                    cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_eq;
  logic [CAPACITY-1:0]      cell_gt;
  logic [CAPACITY-1:0]      cell_valid;

  logic                     hit;
  logic                     full;
  cell_ctrl_t               ctrl;

  count_t                   count_q;
  count_t                   count_d;
  logic                     out_valid_q;
  result_t                  result_q;
  result_t                  result_d;

  assign cmd   = s_axis_tdata[CMD_W-1:0];
  assign value = s_axis_tdata[CMD_W +: VALUE_W];
  assign key   = ELEM_BITS'(value);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign hit  = |cell_eq;
  assign full = (count_q >= CNT_W'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t left_data;
    logic  left_gt;
    elem_t right_data;

    assign cell_valid[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_data = key;
      assign left_gt   = 1'b0;
    end else begin : g_inner
      assign left_data = cell_data[i-1];
      assign left_gt   = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    sst_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .key_i       (key),
      .valid_i     (cell_valid[i]),
      .left_data_i (left_data),
      .left_gt_i   (left_gt),
      .right_data_i(right_data),
      .data_o      (cell_data[i]),
      .eq_o        (cell_eq[i]),
      .gt_o        (cell_gt[i])
    );
  end

  always_comb begin
    ctrl            = '0;
    count_d         = count_q;
    result_d.found  = hit;
    result_d.status = hit ? ST_DONE : ST_ABSENT;
    unique case (cmd)
      CMD_INSERT: begin
        if (hit) begin
          result_d.status = ST_PRESENT;
        end else if (full) begin
          result_d.status = ST_FULL;
        end else begin
          result_d.status = ST_DONE;
          ctrl.insert     = accept;
          count_d         = count_q + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          ctrl.remove = accept;
          count_d     = count_q - 1'b1;
        end
      end
      default: begin
        // Lookup, and the unused code that behaves as one.
      end
    endcase
    result_d.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({result_q.count, result_q.found, result_q.status});

endmodule

`default_nettype wire

@@ rtl/sst_checker.sv @@
// Port-level checker for the sorted set table, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module sst_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sst_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import sst_pkg::*;

  logic [STATUS_W-1:0] status;
  logic                found;
  count_t              count;

  assign status = m_axis_tdata[STATUS_W-1:0];
  assign found  = m_axis_tdata[STATUS_W];
  assign count  = m_axis_tdata[STATUS_W+1 +: CNT_W];

  // A stalled result beat stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // A refused insert only happens with every cell occupied.
  `ASSERT_IMPLIES(a_full_count, clk_i, rst_ni, m_axis_tvalid && (status == ST_FULL), (count == CNT_W'(CAPACITY)) && !found)
  // A held value is reported done or already present, never absent.
  `ASSERT_IMPLIES(a_found_status, clk_i, rst_ni, m_axis_tvalid && found, (status == ST_DONE) || (status == ST_PRESENT))
  // Absent values never report a duplicate.
  `ASSERT_IMPLIES(a_absent_status, clk_i, rst_ni, m_axis_tvalid && !found, status != ST_PRESENT)
  // The count never exceeds the row length.
  `ASSERT_IMPLIES(a_count_range, clk_i, rst_ni, m_axis_tvalid, count <= CNT_W'(CAPACITY))

endmodule

bind sorted_set_table sst_checker u_sst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for the sorted set table, run against a shadow copy of the set.
`timescale 1ns / 1ps

module tb;
  import sst_pkg::*;

  // The spare command code behaves exactly like a lookup.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam elem_t ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};
  localparam elem_t ELEM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};

  localparam int TOTAL_BEATS  = 1750;
  localparam int QUIET_BEATS  = 150;
  localparam int LONG_HOLD    = 400;
  localparam int LONG_HOLD_AT = 500;
  localparam int IDLE_LIMIT   = 5000;
  localparam int ROWS         = 24;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_NOISE} mix_e;

  typedef struct {
    logic [CMD_W-1:0] op;
    elem_t            val;
    bit               lit;
    result_t          want;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Literal expectation that travels alongside the beat on offer.
  bit      beat_lit = 1'b0;
  result_t beat_want = '0;

  elem_t   shadow_set[$];
  result_t pending_results[$];
  elem_t   pool[48];
  int      faults = 0;
  int      beats_sent = 0;
  int      results_seen = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  bit      gaps_on = 1'b1;
  bit      stalls_on = 1'b1;
  bit      long_hold_done = 1'b0;

  row_t plan [ROWS] = '{
    '{CMD_LOOKUP, 32'sd0,         1'b1, '{ST_ABSENT,  1'b0, 6'd0}},
    '{CMD_DELETE, 32'sd0,         1'b1, '{ST_ABSENT,  1'b0, 6'd0}},
    '{CMD_SPARE,  32'sd7,         1'b1, '{ST_ABSENT,  1'b0, 6'd0}},
    '{CMD_INSERT, ELEM_MIN,       1'b1, '{ST_DONE,    1'b0, 6'd1}},
    '{CMD_INSERT, ELEM_MAX,       1'b1, '{ST_DONE,    1'b0, 6'd2}},
    '{CMD_INSERT, ELEM_MIN,       1'b1, '{ST_PRESENT, 1'b1, 6'd2}},
    '{CMD_INSERT, ELEM_MAX,       1'b1, '{ST_PRESENT, 1'b1, 6'd2}},
    '{CMD_LOOKUP, ELEM_MIN,       1'b1, '{ST_DONE,    1'b1, 6'd2}},
    '{CMD_SPARE,  ELEM_MAX,       1'b1, '{ST_DONE,    1'b1, 6'd2}},
    '{CMD_INSERT, 32'sd0,         1'b0, '0},
    '{CMD_INSERT, -32'sd1,        1'b0, '0},
    '{CMD_INSERT, 32'sd1,         1'b0, '0},
    '{CMD_INSERT, 32'sh5555_5555, 1'b0, '0},
    '{CMD_INSERT, 32'shAAAA_AAAA, 1'b0, '0},
    '{CMD_LOOKUP, -32'sd1,        1'b0, '0},
    '{CMD_LOOKUP, 32'sd2,         1'b0, '0},
    '{CMD_DELETE, 32'sd0,         1'b0, '0},
    '{CMD_LOOKUP, 32'sd1,         1'b0, '0},
    '{CMD_DELETE, ELEM_MIN,       1'b0, '0},
    '{CMD_DELETE, ELEM_MIN,       1'b0, '0},
    '{CMD_DELETE, ELEM_MAX,       1'b0, '0},
    '{CMD_SPARE,  ELEM_MAX,       1'b0, '0},
    '{CMD_INSERT, 32'sh8000_0001, 1'b0, '0},
    '{CMD_LOOKUP, 32'sh7FFF_FFFE, 1'b0, '0}
  };

  sorted_set_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Applies one command to the shadow set and returns the result it must produce.
  function automatic result_t set_apply(input logic [CMD_W-1:0] op, input elem_t val);
    result_t r;
    int      pos;
    bit      hit;
    pos = 0;
    while (pos < shadow_set.size() && shadow_set[pos] < val) pos++;
    hit = (pos < shadow_set.size()) && (shadow_set[pos] == val);
    case (op)
      CMD_INSERT: begin
        if (hit) begin
          r.status = ST_PRESENT;
        end else if (shadow_set.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_set.insert(pos, val);
          r.status = ST_DONE;
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          shadow_set.delete(pos);
          r.status = ST_DONE;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: r.status = hit ? ST_DONE : ST_ABSENT;
    endcase
    r.found = hit;
    r.count = count_t'(shadow_set.size());
    return r;
  endfunction

  function automatic elem_t fresh_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      case ($urandom_range(0, 5))
        0: return ELEM_MIN;
        1: return ELEM_MAX;
        2: return elem_t'(0);
        3: return -elem_t'(1);
        4: return ELEM_MIN + elem_t'(1);
        default: return ELEM_MAX - elem_t'(1);
      endcase
    end
    if (roll < 60) return elem_t'(int'($urandom_range(0, 40)) - 20);
    return elem_t'($urandom);
  endfunction

  function automatic elem_t pick_value(input mix_e mix, input int pool_n,
                                       input logic [CMD_W-1:0] op);
    int roll;
    roll = $urandom_range(0, 99);
    if (mix == MIX_NOISE && roll < 60) return elem_t'($urandom);
    if (roll < 8) return elem_t'($urandom);
    // Deletes, lookups and spare commands often aim at values that are held right now.
    if (op != CMD_INSERT && shadow_set.size() > 0 && roll < 55)
      return shadow_set[$urandom_range(0, shadow_set.size() - 1)];
    return pool[$urandom_range(0, pool_n - 1)];
  endfunction

  // Entered and left at a falling edge.
  task automatic offer_beat(input logic [CMD_W-1:0] op, input elem_t val, input bit lit,
                            input result_t want);
    if (gaps_on && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({val, op});
    beat_lit      <= lit;
    beat_want     <= want;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  initial begin : command_source
    mix_e             mix;
    int               epoch;
    int               pool_n;
    int               roll;
    logic [CMD_W-1:0] op;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    foreach (plan[i]) offer_beat(plan[i].op, plan[i].val, plan[i].lit, plan[i].want);
    epoch = 0;
    while (beats_sent < TOTAL_BEATS) begin
      mix = mix_e'(epoch % 4);
      if (epoch == 2) wait_for_results();
      // A fill pool larger than the capacity drives the store into refusals.
      pool_n = (mix == MIX_FILL) ? $urandom_range(36, 48) : $urandom_range(4, 40);
      foreach (pool[i]) pool[i] = fresh_value();
      gap_pct = 10 * $urandom_range(0, 3);
      repeat ($urandom_range(60, 160)) begin
        if (beats_sent >= TOTAL_BEATS) break;
        if (beats_sent >= TOTAL_BEATS - QUIET_BEATS) begin
          gaps_on   = 1'b0;
          stalls_on = 1'b0;
        end
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  op = roll < 70 ? CMD_INSERT : roll < 80 ? CMD_DELETE :
                          roll < 95 ? CMD_LOOKUP : CMD_SPARE;
          MIX_CHURN: op = roll < 35 ? CMD_INSERT : roll < 70 ? CMD_DELETE :
                          roll < 95 ? CMD_LOOKUP : CMD_SPARE;
          MIX_DRAIN: op = roll < 15 ? CMD_INSERT : roll < 75 ? CMD_DELETE :
                          roll < 95 ? CMD_LOOKUP : CMD_SPARE;
          default:   op = roll < 30 ? CMD_INSERT : roll < 55 ? CMD_DELETE :
                          roll < 85 ? CMD_LOOKUP : CMD_SPARE;
        endcase
        offer_beat(op, pick_value(mix, pool_n, op), 1'b0, '0);
      end
      epoch++;
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (faults == 0) begin
      $display("sorted_set_table: match");
    end else begin
      $display("sorted_set_table: mismatch");
    end
    $finish;
  end

  initial begin : result_sink
    int hold;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold = LONG_HOLD;
      end else if (stalls_on && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 19);
      end else begin
        hold = 0;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 63) == 0) stall_pct = 10 * $urandom_range(0, 4);
    end
  end

  always @(posedge clk_i) begin : scoreboard
    result_t          want;
    result_t          got;
    result_t          predicted;
    logic [CMD_W-1:0] op;
    elem_t            val;
    if (rst_ni) begin
      // A result beat always belongs to an earlier command, so it is checked first.
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got.status = status_e'(m_axis_tdata[STATUS_W-1:0]);
        got.found  = m_axis_tdata[STATUS_W];
        got.count  = m_axis_tdata[STATUS_W+1 +: CNT_W];
        if (pending_results.size() == 0) begin
          $display("%0t: result beat %h with nothing expected", $time, m_axis_tdata);
          faults++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            faults++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
            faults++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
            faults++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op  = s_axis_tdata[CMD_W-1:0];
        val = s_axis_tdata[CMD_W +: VALUE_W];
        predicted = set_apply(op, val);
        pending_results.push_back(beat_lit ? beat_want : predicted);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else
        idle++;
    end
    $display("sorted_set_table: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sorted_set_table.sv
rtl/sst_checker.sv
sim/tb.sv
